/* design/rta_pkg.sv */
// ----------------------------------------------------------------------------
// rta_pkg
// Shared types, constants and helpers for request time accounting.
// ----------------------------------------------------------------------------
`default_nettype none

package rta_pkg;

  // Slot store geometry
  localparam int unsigned SLOTS  = 16;
  localparam int unsigned SLOT_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;

  // Field widths
  localparam int unsigned TIME_W = 64;
  localparam int unsigned ID_W   = 4;
  localparam int unsigned CMD_W  = 2;
  localparam int unsigned ST_W   = 2;
  localparam int unsigned IDS    = 2 ** ID_W;

  typedef logic [TIME_W-1:0] time_t;
  typedef logic [SLOT_W-1:0] slot_t;

  // Event kinds
  typedef enum logic [CMD_W-1:0] {
    CMD_START  = 2'd0,
    CMD_YIELD  = 2'd1,
    CMD_RESUME = 2'd2,
    CMD_END    = 2'd3
  } cmd_t;

  // Result status codes
  typedef enum logic [ST_W-1:0] {
    ST_OK        = 2'd0,
    ST_BACKWARDS = 2'd1,
    ST_PHASE     = 2'd2
  } status_t;

  // One slot row as kept in the slot RAM
  typedef struct packed {
    time_t resume_stamp;
    time_t yield_stamp;
    time_t run_total;
    time_t wait_total;
  } row_t;

  // Control from the sequencer to the worker unit
  typedef struct packed {
    logic sum_en;   // add totals, form prediction delta
    logic pred_en;  // finish prediction
    logic apply;    // event is an accepted end
  } wrk_ctl_t;

  // Request id to slot: wrap by counting, no divider
  typedef logic [IDS-1:0][SLOT_W-1:0] slot_map_t;

  function automatic slot_map_t build_slot_map();
    slot_map_t   map;
    int unsigned cnt;
    cnt = 0;
    for (int i = 0; i < IDS; i++) begin
      map[i] = SLOT_W'(cnt);
      cnt    = (cnt == SLOTS - 1) ? 0 : cnt + 1;
    end
    return map;
  endfunction

  localparam slot_map_t SLOT_MAP = build_slot_map();

  // Saturating unsigned add
  function automatic time_t sat_add(time_t a, time_t b);
    logic [TIME_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[TIME_W] ? {TIME_W{1'b1}} : s[TIME_W-1:0];
  endfunction

endpackage

`default_nettype wire

/* design/rta_if.sv */
// ----------------------------------------------------------------------------
// rta_if
// Valid/ready channels for accounting events and results.
// ----------------------------------------------------------------------------
`default_nettype none

interface rta_in_if;
  logic                       valid;
  logic                       ready;
  logic [rta_pkg::CMD_W-1:0]  cmd;
  logic [rta_pkg::ID_W-1:0]   req_id;
  logic [rta_pkg::TIME_W-1:0] event_time;

  modport source (output valid, output cmd, output req_id, output event_time,
                  input ready);
  modport sink   (input valid, input cmd, input req_id, input event_time,
                  output ready);
endinterface

interface rta_out_if;
  logic                       valid;
  logic                       ready;
  logic [rta_pkg::ST_W-1:0]   status;
  logic [rta_pkg::TIME_W-1:0] req_running;
  logic [rta_pkg::TIME_W-1:0] req_waiting;
  logic [rta_pkg::TIME_W-1:0] worker_running;
  logic [rta_pkg::TIME_W-1:0] worker_waiting;
  logic [rta_pkg::TIME_W-1:0] worker_predicted;

  modport source (output valid, output status, output req_running,
                  output req_waiting, output worker_running,
                  output worker_waiting, output worker_predicted,
                  input ready);
  modport sink   (input valid, input status, input req_running,
                  input req_waiting, input worker_running,
                  input worker_waiting, input worker_predicted,
                  output ready);
endinterface

`default_nettype wire

/* design/rta_slot_ram.sv */
// ----------------------------------------------------------------------------
// rta_slot_ram
// Per-slot stamps and totals: one write port, one registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module rta_slot_ram (
  input  wire logic           clk,
  input  wire logic           rd_en,
  input  wire rta_pkg::slot_t rd_addr,
  output rta_pkg::row_t       rd_data_r,
  input  wire logic           wr_en,
  input  wire rta_pkg::slot_t wr_addr,
  input  wire rta_pkg::row_t  wr_data
);

  rta_pkg::row_t mem [rta_pkg::SLOTS];

  // Write back modified row
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Registered read
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

/* design/rta_worker.sv */
// ----------------------------------------------------------------------------
// rta_worker
// Worker running/waiting sums and moving-average service time prediction.
// ----------------------------------------------------------------------------
`default_nettype none

module rta_worker (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire rta_pkg::wrk_ctl_t ctl,
  input  wire rta_pkg::time_t    run_val,
  input  wire rta_pkg::time_t    wait_val,
  output rta_pkg::time_t         run_sum,
  output rta_pkg::time_t         wait_sum,
  output rta_pkg::time_t         predicted
);

  rta_pkg::time_t run_sum_r;
  rta_pkg::time_t wait_sum_r;
  rta_pkg::time_t pred_r;
  rta_pkg::time_t pred_nxt;

  // Prediction delta, held between the two steps
  rta_pkg::time_t d_r;
  rta_pkg::time_t nv_r;
  logic           up_r;
  logic           zero_r;

  logic [rta_pkg::TIME_W:0] up_diff;
  logic [rta_pkg::TIME_W:0] dn_diff;

  // Both differences side by side; the sign picks one
  assign up_diff = {1'b0, run_val} - {1'b0, pred_r};
  assign dn_diff = {1'b0, pred_r} - {1'b0, run_val};

  // Finish (new + 7*old)/8 as old + delta/8, rounding toward floor; a zero prediction loads the new value
  always_comb begin
    if (zero_r) begin
      pred_nxt = nv_r;
    end else if (up_r) begin
      pred_nxt = pred_r + (d_r >> 3);
    end else begin
      pred_nxt = pred_r - (d_r >> 3) - rta_pkg::TIME_W'(|d_r[2:0]);
    end
  end

  // Hold sums and prediction
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_sum_r  <= '0;
      wait_sum_r <= '0;
      pred_r     <= '0;
    end else begin
      if (ctl.sum_en && ctl.apply) begin
        run_sum_r  <= rta_pkg::sat_add(run_sum_r, run_val);
        wait_sum_r <= rta_pkg::sat_add(wait_sum_r, wait_val);
      end
      if (ctl.pred_en && ctl.apply) begin
        pred_r <= pred_nxt;
      end
    end
  end

  // Capture delta for the second step
  always_ff @(posedge clk) begin
    if (ctl.sum_en) begin
      nv_r   <= run_val;
      zero_r <= (pred_r == '0);
      up_r   <= !up_diff[rta_pkg::TIME_W];
      d_r    <= up_diff[rta_pkg::TIME_W] ? dn_diff[rta_pkg::TIME_W-1:0]
                                         : up_diff[rta_pkg::TIME_W-1:0];
    end
  end

  assign run_sum   = run_sum_r;
  assign wait_sum  = wait_sum_r;
  assign predicted = pred_r;

endmodule

`default_nettype wire

/* design/request_time_accounting_core.sv */
// ----------------------------------------------------------------------------
// request_time_accounting_core
// Per-request running/waiting time accounting with worker prediction.
// ----------------------------------------------------------------------------
// Events enter on in_ch (cmd, req_id, event_time) and each gives exactly one
// result on out_ch: a status plus the slot and worker totals after the event.
// Both channels transfer when valid and ready are high at a rising edge.
// An event goes through six steps: accept and read the slot RAM, check phase
// and time, modify and write back the slot row, add the worker sums, finish
// the prediction, and load the result register. The next event is taken only
// after that load, once the slot read-modify-write and both worker steps end.
// in_ch.ready is high only while the sequencer waits for an event, so two
// events on the same slot never overlap in the RAM.
// Reset clears the waiting flags, the worker sums and the prediction. The
// slot RAM is not cleared: every slot must see a start before other events.
// When the receiver stalls, the result stays in the output register; one
// further event is accepted and waits in its last step until that register
// frees.
// ----------------------------------------------------------------------------
`default_nettype none

module request_time_accounting_core (
  input wire logic  clk,
  input wire logic  rst_n,
  rta_in_if.sink    in_ch,
  rta_out_if.source out_ch
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_LOOK,
    S_ACC,
    S_WRK1,
    S_WRK2,
    S_FIN
  } state_t;

  state_t state_r;

  // Event registers
  rta_pkg::cmd_t    cmd_r;
  rta_pkg::slot_t   slot_r;
  rta_pkg::time_t   time_r;

  // Check results
  rta_pkg::status_t st_r;
  rta_pkg::status_t st_nxt;
  rta_pkg::time_t   diff_r;
  rta_pkg::row_t    row_r;

  // Slot results
  rta_pkg::time_t   run_res_r;
  rta_pkg::time_t   wait_res_r;
  logic             apply_r;

  logic [rta_pkg::SLOTS-1:0] wait_bits_r;

  // Output register
  logic                       out_valid_r;
  logic [rta_pkg::ST_W-1:0]   out_status_r;
  rta_pkg::time_t             out_run_r;
  rta_pkg::time_t             out_wait_r;
  rta_pkg::time_t             out_wrun_r;
  rta_pkg::time_t             out_wwait_r;
  rta_pkg::time_t             out_pred_r;

  logic                       in_xfer;
  logic                       out_load;
  rta_pkg::slot_t             rd_slot;
  rta_pkg::row_t              rd_row;
  rta_pkg::row_t              new_row;
  rta_pkg::row_t              res_row;
  logic                       ram_wr_en;
  logic                       waiting;
  logic                       phase_err;
  rta_pkg::time_t             stamp;
  logic [rta_pkg::TIME_W:0]   span;
  logic                       ok;
  rta_pkg::wrk_ctl_t          wrk_ctl;
  rta_pkg::time_t             w_run;
  rta_pkg::time_t             w_wait;
  rta_pkg::time_t             w_pred;

  assign in_ch.ready = (state_r == S_IDLE);
  assign in_xfer     = in_ch.valid && in_ch.ready;
  assign rd_slot     = rta_pkg::SLOT_MAP[in_ch.req_id];
  assign out_load    = (state_r == S_FIN) && (!out_valid_r || out_ch.ready);

  rta_slot_ram u_ram (
    .clk       (clk),
    .rd_en     (in_xfer),
    .rd_addr   (rd_slot),
    .rd_data_r (rd_row),
    .wr_en     (ram_wr_en),
    .wr_addr   (slot_r),
    .wr_data   (new_row)
  );

  // Check phase, then time, on the freshly read row
  always_comb begin
    waiting = wait_bits_r[slot_r];
    stamp   = (cmd_r == rta_pkg::CMD_RESUME) ? rd_row.yield_stamp
                                             : rd_row.resume_stamp;
    span    = {1'b0, time_r} - {1'b0, stamp};
    case (cmd_r)
      rta_pkg::CMD_START:  phase_err = 1'b0;
      rta_pkg::CMD_RESUME: phase_err = !waiting;
      default:             phase_err = waiting;
    endcase
    if (cmd_r == rta_pkg::CMD_START) begin
      st_nxt = rta_pkg::ST_OK;
    end else if (phase_err) begin
      st_nxt = rta_pkg::ST_PHASE;
    end else if (span[rta_pkg::TIME_W]) begin
      st_nxt = rta_pkg::ST_BACKWARDS;
    end else begin
      st_nxt = rta_pkg::ST_OK;
    end
  end

  // Modify the slot row
  always_comb begin
    new_row = row_r;
    case (cmd_r)
      rta_pkg::CMD_START: begin
        new_row.resume_stamp = time_r;
        new_row.yield_stamp  = '0;
        new_row.run_total    = '0;
        new_row.wait_total   = '0;
      end
      rta_pkg::CMD_YIELD: begin
        new_row.yield_stamp = time_r;
        new_row.run_total   = rta_pkg::sat_add(row_r.run_total, diff_r);
      end
      rta_pkg::CMD_RESUME: begin
        new_row.resume_stamp = time_r;
        new_row.wait_total   = rta_pkg::sat_add(row_r.wait_total, diff_r);
      end
      default: begin
        new_row.run_total = rta_pkg::sat_add(row_r.run_total, diff_r);
      end
    endcase
    ok        = (st_r == rta_pkg::ST_OK);
    res_row   = ok ? new_row : row_r;
    ram_wr_en = (state_r == S_ACC) && ok;
  end

  assign wrk_ctl.sum_en  = (state_r == S_WRK1);
  assign wrk_ctl.pred_en = (state_r == S_WRK2);
  assign wrk_ctl.apply   = apply_r;

  rta_worker u_worker (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctl       (wrk_ctl),
    .run_val   (run_res_r),
    .wait_val  (wait_res_r),
    .run_sum   (w_run),
    .wait_sum  (w_wait),
    .predicted (w_pred)
  );

  // Sequence one event, hold the waiting flags and the result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      wait_bits_r <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (out_valid_r && out_ch.ready && !out_load) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        S_IDLE: begin
          if (in_xfer) begin
            state_r <= S_LOOK;
          end
        end
        S_LOOK: state_r <= S_ACC;
        S_ACC: begin
          if (ok) begin
            case (cmd_r)
              rta_pkg::CMD_START:  wait_bits_r[slot_r] <= 1'b0;
              rta_pkg::CMD_YIELD:  wait_bits_r[slot_r] <= 1'b1;
              rta_pkg::CMD_RESUME: wait_bits_r[slot_r] <= 1'b0;
              default:             ;
            endcase
          end
          state_r <= S_WRK1;
        end
        S_WRK1: state_r <= S_WRK2;
        S_WRK2: state_r <= S_FIN;
        S_FIN: begin
          if (out_load) begin
            out_valid_r <= 1'b1;
            state_r     <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      cmd_r  <= rta_pkg::cmd_t'(in_ch.cmd);
      slot_r <= rd_slot;
      time_r <= in_ch.event_time;
    end
    if (state_r == S_LOOK) begin
      st_r   <= st_nxt;
      diff_r <= span[rta_pkg::TIME_W-1:0];
      row_r  <= rd_row;
    end
    if (state_r == S_ACC) begin
      run_res_r  <= res_row.run_total;
      wait_res_r <= res_row.wait_total;
      apply_r    <= ok && (cmd_r == rta_pkg::CMD_END);
    end
    if (out_load) begin
      out_status_r <= st_r;
      out_run_r    <= run_res_r;
      out_wait_r   <= wait_res_r;
      out_wrun_r   <= w_run;
      out_wwait_r  <= w_wait;
      out_pred_r   <= w_pred;
    end
  end

  assign out_ch.valid            = out_valid_r;
  assign out_ch.status           = out_status_r;
  assign out_ch.req_running      = out_run_r;
  assign out_ch.req_waiting      = out_wait_r;
  assign out_ch.worker_running   = out_wrun_r;
  assign out_ch.worker_waiting   = out_wwait_r;
  assign out_ch.worker_predicted = out_pred_r;

  // An accepted event always starts the slot lookup next
  a_xfer_look: assert property (@(posedge clk) disable iff (!rst_n)
    in_xfer |=> (state_r == S_LOOK))
    else $error("event accepted without slot lookup");

  // A rejected event never writes the slot RAM
  a_err_no_write: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_ACC) && (st_r != rta_pkg::ST_OK) |-> !ram_wr_en)
    else $error("error event wrote slot RAM");

  // Waiting flags move only in the modify step
  a_flags_stable: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != S_ACC) |=> $stable(wait_bits_r))
    else $error("waiting flags changed outside modify step");

  // A rejected event never applies to the worker sums or prediction
  a_err_no_apply: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_WRK1) && (st_r != rta_pkg::ST_OK) |-> !apply_r)
    else $error("error event applied to worker");

endmodule

`default_nettype wire

/* bench/tb_top.sv */
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for request_time_accounting_core.
// ----------------------------------------------------------------------------
// Accounting events go in over the valid/ready input channel. A monitor at
// each rising edge updates a local copy of the slot and worker state for
// every event transfer. It queues the result that the event should give and
// compares every result transfer, field by field, with the oldest entry.
// A directed run covers saturation, phase and time errors, repeated ends and
// the prediction. Random runs follow, made mostly of well-formed
// start/yield/resume/end sequences with some noise. Both sides stall at
// random in some phases and run flat out in others.
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import rta_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 400000;
  localparam int unsigned IDLE_PCT    = 16;
  localparam time_t       T_MAX       = '1;

  typedef struct {
    status_t status;
    time_t   req_running;
    time_t   req_waiting;
    time_t   worker_running;
    time_t   worker_waiting;
    time_t   worker_predicted;
  } acct_result_t;

  logic clk;
  logic rst_n;

  rta_in_if  in_ch();
  rta_out_if out_ch();

  request_time_accounting_core dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  // Local copy of the block state
  time_t        resume_at  [SLOTS];
  time_t        yield_at   [SLOTS];
  time_t        run_acc    [SLOTS];
  time_t        wait_acc   [SLOTS];
  logic [SLOTS-1:0] slot_waiting;
  logic [SLOTS-1:0] slot_started;
  time_t        total_run;
  time_t        total_wait;
  time_t        service_estimate;

  acct_result_t expected_acct[$];
  int unsigned  err_count;
  int unsigned  cycle_count;
  logic         src_idle_en;
  logic         sink_idle_en;

  // Clock
  initial clk = 1'b0;
  always #1 clk = ~clk;

  // Saturating sum
  function automatic time_t sum_sat(time_t a, time_t b);
    time_t s;
    s = a + b;
    return (s < a) ? T_MAX : s;
  endfunction

  // Service-time average: floor((nv + 7*old) / 8) without overflow
  function automatic time_t blend_estimate(time_t old, time_t nv);
    time_t d;
    if (nv >= old) begin
      d = nv - old;
      return old + (d >> 3);
    end
    d = old - nv;
    return old - ((d >> 3) + time_t'(d[2:0] != 3'd0));
  endfunction

  // Apply one event to the local state and return the result it gives
  function automatic acct_result_t account_event(cmd_t c, logic [ID_W-1:0] id, time_t t);
    acct_result_t r;
    int unsigned  s;
    s = int'(id) % SLOTS;
    r.status = ST_OK;
    case (c)
      CMD_START: begin
        resume_at[s]    = t;
        yield_at[s]     = '0;
        run_acc[s]      = '0;
        wait_acc[s]     = '0;
        slot_waiting[s] = 1'b0;
        slot_started[s] = 1'b1;
      end
      CMD_YIELD: begin
        if (slot_waiting[s]) begin
          r.status = ST_PHASE;
        end else if (t < resume_at[s]) begin
          r.status = ST_BACKWARDS;
        end else begin
          yield_at[s]     = t;
          run_acc[s]      = sum_sat(run_acc[s], t - resume_at[s]);
          slot_waiting[s] = 1'b1;
        end
      end
      CMD_RESUME: begin
        if (!slot_waiting[s]) begin
          r.status = ST_PHASE;
        end else if (t < yield_at[s]) begin
          r.status = ST_BACKWARDS;
        end else begin
          resume_at[s]    = t;
          wait_acc[s]     = sum_sat(wait_acc[s], t - yield_at[s]);
          slot_waiting[s] = 1'b0;
        end
      end
      default: begin
        if (slot_waiting[s]) begin
          r.status = ST_PHASE;
        end else if (t < resume_at[s]) begin
          r.status = ST_BACKWARDS;
        end else begin
          run_acc[s] = sum_sat(run_acc[s], t - resume_at[s]);
          total_run  = sum_sat(total_run, run_acc[s]);
          total_wait = sum_sat(total_wait, wait_acc[s]);
          if (service_estimate == '0) begin
            service_estimate = run_acc[s];
          end else begin
            service_estimate = blend_estimate(service_estimate, run_acc[s]);
          end
        end
      end
    endcase
    r.req_running      = run_acc[s];
    r.req_waiting      = wait_acc[s];
    r.worker_running   = total_run;
    r.worker_waiting   = total_wait;
    r.worker_predicted = service_estimate;
    return r;
  endfunction

  function automatic void check_field(string name, time_t exp_v, time_t act_v);
    if (exp_v !== act_v) begin
      $error("%s mismatch: expected 0x%0h, actual 0x%0h", name, exp_v, act_v);
      err_count++;
    end
  endfunction

  // Monitor: predict on each event transfer, compare on each result transfer
  always @(posedge clk) begin
    acct_result_t want;
    if (rst_n) begin
      if (in_ch.valid && in_ch.ready) begin
        expected_acct.push_back(account_event(cmd_t'(in_ch.cmd), in_ch.req_id,
                                              in_ch.event_time));
      end
      if (out_ch.valid && out_ch.ready) begin
        if (expected_acct.size() == 0) begin
          $error("result transfer with no event outstanding");
          err_count++;
        end else begin
          want = expected_acct.pop_front();
          check_field("status", time_t'(want.status), time_t'(out_ch.status));
          check_field("req_running", want.req_running, out_ch.req_running);
          check_field("req_waiting", want.req_waiting, out_ch.req_waiting);
          check_field("worker_running", want.worker_running, out_ch.worker_running);
          check_field("worker_waiting", want.worker_waiting, out_ch.worker_waiting);
          check_field("worker_predicted", want.worker_predicted,
                      out_ch.worker_predicted);
        end
      end
    end
  end

  // Result side: stall at random while enabled
  always @(negedge clk) begin
    out_ch.ready <= !(sink_idle_en && ($urandom_range(99) < IDLE_PCT));
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  // Drive one event and hold it until transfer; entered and left at a falling edge
  task automatic send_event(cmd_t c, logic [ID_W-1:0] id, time_t t);
    while (src_idle_en && ($urandom_range(99) < IDLE_PCT)) begin
      in_ch.valid <= 1'b0;
      @(negedge clk);
    end
    in_ch.valid      <= 1'b1;
    in_ch.cmd        <= c;
    in_ch.req_id     <= id;
    in_ch.event_time <= t;
    @(posedge clk);
    while (in_ch.ready !== 1'b1) @(posedge clk);
    @(negedge clk);
  endtask

  function automatic time_t rand_word64();
    return {$urandom, $urandom};
  endfunction

  // Time step after a stamp, clamped at the top of the range
  function automatic time_t later_than(time_t base);
    time_t   delta;
    time_t   t;
    int unsigned pick;
    pick = $urandom_range(99);
    if (pick < 2) begin
      delta = '0;
    end else if (pick < 7) begin
      delta = rand_word64();
    end else begin
      delta = time_t'($urandom_range(5000));
    end
    t = base + delta;
    return (t < base) ? T_MAX : t;
  endfunction

  function automatic time_t start_stamp();
    int unsigned pick;
    pick = $urandom_range(99);
    if (pick < 70) return time_t'($urandom);
    if (pick < 90) return rand_word64();
    return T_MAX - time_t'($urandom_range(1000));
  endfunction

  // One random event: mostly well-formed per slot, some noise
  task automatic send_random_event();
    logic [ID_W-1:0] id;
    int unsigned     s;
    int unsigned     roll;
    cmd_t            c;
    time_t           t;
    id   = ID_W'($urandom_range(IDS - 1));
    s    = int'(id) % SLOTS;
    roll = $urandom_range(99);
    if (!slot_started[s] || roll < 6) begin
      c = CMD_START;
      t = start_stamp();
    end else if (roll < 14) begin
      // noise: any kind, any time
      c = cmd_t'($urandom_range(3));
      t = ($urandom_range(1)) ? rand_word64() : time_t'($urandom);
    end else if (roll < 18) begin
      // broken sequence: right kind, time just before the stamp
      c = slot_waiting[s] ? CMD_RESUME : (($urandom_range(1)) ? CMD_YIELD : CMD_END);
      t = slot_waiting[s] ? yield_at[s] : resume_at[s];
      t = (t == '0) ? '0 : t - time_t'($urandom_range(1, 100));
    end else if (slot_waiting[s]) begin
      c = CMD_RESUME;
      t = later_than(yield_at[s]);
    end else begin
      c = ($urandom_range(99) < 60) ? CMD_YIELD : CMD_END;
      t = later_than(resume_at[s]);
    end
    send_event(c, id, t);
  endtask

  // Saturation, phase and time errors, check order, repeated end, prediction
  task automatic test_directed();
    send_event(CMD_START,  4'd0,  64'd0);
    send_event(CMD_YIELD,  4'd0,  T_MAX);
    send_event(CMD_RESUME, 4'd0,  T_MAX);
    // not waiting and earlier than the yield stamp: phase wins
    send_event(CMD_RESUME, 4'd0,  64'd3);
    send_event(CMD_END,    4'd0,  64'd1);
    // first end loads the empty prediction
    send_event(CMD_END,    4'd0,  T_MAX);
    // repeated end saturates the worker running sum
    send_event(CMD_END,    4'd0,  T_MAX);
    send_event(CMD_START,  4'd15, 64'd100);
    send_event(CMD_YIELD,  4'd15, 64'd99);
    send_event(CMD_YIELD,  4'd15, 64'd160);
    send_event(CMD_END,    4'd15, 64'd200);
    send_event(CMD_YIELD,  4'd15, 64'd50);
    send_event(CMD_RESUME, 4'd15, 64'd150);
    send_event(CMD_RESUME, 4'd15, 64'd170);
    send_event(CMD_END,    4'd15, 64'd183);
    // restart clears totals
    send_event(CMD_START,  4'd0,  T_MAX);
    send_event(CMD_END,    4'd0,  T_MAX);
    send_event(CMD_START,  4'd7,  64'd0);
    send_event(CMD_YIELD,  4'd7,  64'd0);
    send_event(CMD_RESUME, 4'd7,  T_MAX);
    send_event(CMD_END,    4'd7,  T_MAX);
    send_event(CMD_END,    4'd7,  T_MAX);
  endtask

  task automatic test_random_stalls(int unsigned n);
    src_idle_en  = 1'b1;
    sink_idle_en = 1'b1;
    repeat (n) send_random_event();
  endtask

  task automatic test_random_back_to_back(int unsigned n);
    src_idle_en  = 1'b0;
    sink_idle_en = 1'b0;
    repeat (n) send_random_event();
  endtask

  // Hold off the sender until every outstanding result has transferred
  task automatic test_drain_pause(int unsigned n);
    src_idle_en  = 1'b1;
    sink_idle_en = 1'b1;
    in_ch.valid <= 1'b0;
    wait (expected_acct.size() == 0);
    @(negedge clk);
    repeat (n) send_random_event();
  endtask

  initial begin
    for (int i = 0; i < SLOTS; i++) begin
      resume_at[i] = '0;
      yield_at[i]  = '0;
      run_acc[i]   = '0;
      wait_acc[i]  = '0;
    end
    slot_waiting     = '0;
    slot_started     = '0;
    total_run        = '0;
    total_wait       = '0;
    service_estimate = '0;
    err_count        = 0;
    cycle_count      = 0;
    src_idle_en      = 1'b0;
    sink_idle_en     = 1'b0;
    rst_n            = 1'b0;
    in_ch.valid      = 1'b0;
    in_ch.cmd        = '0;
    in_ch.req_id     = '0;
    in_ch.event_time = '0;
    out_ch.ready     = 1'b0;

    // Hold reset, then release at a falling edge
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    test_directed();
    test_random_stalls(700);
    test_random_back_to_back(500);
    test_drain_pause(300);
    test_random_stalls(250);

    // Drop valid, drain, allow for the pipeline
    in_ch.valid <= 1'b0;
    src_idle_en  = 1'b0;
    sink_idle_en = 1'b0;
    wait (expected_acct.size() == 0);
    repeat (12) @(posedge clk);
    if (err_count == 0 && expected_acct.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

/* filelist.f */
design/rta_pkg.sv
design/rta_if.sv
design/rta_slot_ram.sv
design/rta_worker.sv
design/request_time_accounting_core.sv
bench/tb_top.sv
